// ----- design/imm_pkg.sv -----
package imm_pkg;

  localparam int ORDER_W     = 5;
  localparam int IDX_W       = 4;
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 2;
  localparam int FIELD_REACH = 16;

  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ----- design/imm_in_if.sv -----
interface imm_in_if import imm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [DATA_W-1:0] in_value;

  modport source (output valid, action, in_row, in_col, in_value, input ready);
  modport sink   (input valid, action, in_row, in_col, in_value, output ready);
endinterface

// ----- design/imm_out_if.sv -----
interface imm_out_if import imm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  out_row;
  logic [IDX_W-1:0]  out_col;
  logic [DATA_W-1:0] out_value;
  logic              last_of_row;

  modport source (output valid, out_row, out_col, out_value, last_of_row, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last_of_row, output ready);
endinterface

// ----- design/imm_front.sv -----
module imm_front import imm_pkg::*; (
  input  logic [ORDER_W-1:0] order_eff,
  imm_in_if.sink             in_chan,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd
);

  logic row_ok;
  logic col_ok;
  logic keep;

  assign in_chan.ready = !q_full;
  assign row_ok = {1'b0, in_chan.in_row} < order_eff;
  assign col_ok = {1'b0, in_chan.in_col} < order_eff;

  always_comb begin
    case (in_chan.action)
      ACT_LOAD_A:  keep = row_ok && col_ok;
      ACT_LOAD_B:  keep = row_ok && col_ok;
      ACT_COMPUTE: keep = row_ok;
      default:     keep = 1'b0;
    endcase
  end

  // drop items that fall outside the matrix in use or carry an unused action
  assign push = in_chan.valid && in_chan.ready && keep;
  assign push_cmd.action = in_chan.action;
  assign push_cmd.row    = in_chan.in_row;
  assign push_cmd.col    = in_chan.in_col;
  assign push_cmd.value  = in_chan.in_value;

endmodule

// ----- design/imm_queue.sv -----
module imm_queue import imm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && q_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop && q_valid);
    end
  end

endmodule

// ----- design/imm_back.sv -----
module imm_back import imm_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ORDER_W-1:0] order_eff,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               pop,
  imm_out_if.source          out_chan
);

  localparam int LW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ORDER_W-1:0] k_r, k_nxt;
  logic [ORDER_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic               rd_v_r, mul_v_r;
  logic               acc_clr;
  logic               wr_a, wr_b;
  logic               emit;
  logic [ORDER_W-1:0] last_idx;

  logic [DATA_W-1:0] mem_a [MAX_ORDER*MAX_ORDER];
  logic [DATA_W-1:0] a_rd_r;
  logic [DATA_W-1:0] b_rd_r [MAX_ORDER];
  logic [DATA_W-1:0] prod_r [MAX_ORDER];
  logic [DATA_W-1:0] acc_r  [MAX_ORDER];
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  logic              out_v_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;

  assign last_idx = order_eff - ORDER_W'(1);
  assign pop      = (state_r == ST_IDLE) && q_valid;
  assign wr_a     = pop && (q_cmd.action == ACT_LOAD_A);
  assign wr_b     = pop && (q_cmd.action == ACT_LOAD_B);
  assign acc_clr  = pop && (q_cmd.action == ACT_COMPUTE);
  assign emit     = (state_r == ST_EMIT) && (!out_v_r || out_chan.ready);
  assign wr_addr  = AW'(AW'(q_cmd.row) * AW'(MAX_ORDER) + AW'(q_cmd.col));
  assign rd_addr  = AW'(AW'(row_r) * AW'(MAX_ORDER) + AW'(k_r));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= q_cmd.value;
    end
    a_rd_r <= mem_a[rd_addr];
  end

  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_lane
    logic [DATA_W-1:0] col_mem [MAX_ORDER];

    always_ff @(posedge clk) begin
      if (wr_b && (LW'(q_cmd.col) == LW'(g))) begin
        col_mem[LW'(q_cmd.row)] <= q_cmd.value;
      end
      b_rd_r[g] <= col_mem[LW'(k_r)];
      prod_r[g] <= a_rd_r * b_rd_r[g];
      if (acc_clr) begin
        acc_r[g] <= '0;
      end else if (mul_v_r) begin
        acc_r[g] <= acc_r[g] + prod_r[g];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_clr) begin
          row_nxt   = q_cmd.row;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        k_nxt = k_r + ORDER_W'(1);
        if (k_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mul_v_r) begin
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          j_nxt = j_r + ORDER_W'(1);
          if (j_r == last_idx) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= state_r == ST_MAC;
      mul_v_r <= rd_v_r;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    row_r <= row_nxt;
    if (emit) begin
      out_row_r   <= row_r;
      out_col_r   <= IDX_W'(j_r);
      out_value_r <= acc_r[LW'(j_r)];
      out_last_r  <= j_r == last_idx;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.out_row     = out_row_r;
  assign out_chan.out_col     = out_col_r;
  assign out_chan.out_value   = out_value_r;
  assign out_chan.last_of_row = out_last_r;

endmodule

// ----- design/integer_matrix_multiply.sv -----
// Channel   Direction  Handshake        Payload
// in_chan   input      valid / ready    action, in_row, in_col, in_value
// out_chan  output     valid / ready    out_row, out_col, out_value, last_of_row
// cfg_*     input      write enable     matrix_order
//
// A load is stored as it is popped. A compute row of order n runs n
// multiply-accumulate steps across one lane per column, drains the pipeline, then emits
// the n results; out_chan back-pressure stalls the emit, and no command is popped
// until the row is out. Synchronous active-low reset clears control state; the matrix
// stores are undefined until loaded. A two-entry queue parts intake from execution.
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [ORDER_W-1:0] cfg_wr_data,
  imm_in_if.sink             in_chan,
  imm_out_if.source          out_chan
);

  localparam int CAP = (MAX_ORDER < FIELD_REACH) ? MAX_ORDER : FIELD_REACH;

  logic [ORDER_W-1:0] order_r;
  logic [ORDER_W-1:0] order_eff;
  logic               push;
  cmd_t               push_cmd;
  logic               q_full;
  logic               q_valid;
  cmd_t               q_cmd;
  logic               pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(16);
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  assign order_eff = (order_r > ORDER_W'(CAP)) ? ORDER_W'(CAP) : order_r;

  imm_front u_front (
    .order_eff (order_eff),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  imm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  imm_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .order_eff (order_eff),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import imm_pkg::*;

  localparam int STORE_N = 16;
  localparam int DRAIN = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } product_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0] cfg_wr_data = '0;

  imm_in_if  in_if ();
  imm_out_if out_if ();

  integer_matrix_multiply #(.MAX_ORDER(STORE_N)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_if.sink),
    .out_chan    (out_if.source)
  );

  logic [DATA_W-1:0] left_mat  [STORE_N*STORE_N];
  logic [DATA_W-1:0] right_mat [STORE_N*STORE_N];
  bit                left_set  [STORE_N*STORE_N];
  bit                right_set [STORE_N*STORE_N];
  logic [ORDER_W-1:0] order_reg = 5'd16;
  product_t          product_q[$];
  int                errors = 0;
  int                cycles = 0;
  bit                steady = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("integer_matrix_multiply test failed");
      $finish;
    end
  end

  function automatic int live_order();
    return (order_reg > STORE_N) ? STORE_N : int'(order_reg);
  endfunction

  function automatic bit row_ready(int r);
    int n;
    n = live_order();
    for (int k = 0; k < n; k++) begin
      if (!left_set[r*STORE_N+k]) return 1'b0;
      for (int j = 0; j < n; j++)
        if (!right_set[k*STORE_N+j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic apply_cmd(logic [ACT_W-1:0] act, int r, int c, logic [DATA_W-1:0] v);
    int n;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] prod;
    product_t p;
    n = live_order();
    if (r >= n) return;
    if (act == ACT_LOAD_A || act == ACT_LOAD_B) begin
      if (c >= n) return;
      if (act == ACT_LOAD_A) begin
        left_mat[r*STORE_N+c] = v;
        left_set[r*STORE_N+c] = 1'b1;
      end else begin
        right_mat[r*STORE_N+c] = v;
        right_set[r*STORE_N+c] = 1'b1;
      end
    end else if (act == ACT_COMPUTE) begin
      for (int j = 0; j < n; j++) begin
        sum = '0;
        for (int k = 0; k < n; k++) begin
          prod = left_mat[r*STORE_N+k] * right_mat[k*STORE_N+j];
          sum = sum + prod;
        end
        p.row = r[IDX_W-1:0];
        p.col = j[IDX_W-1:0];
        p.value = sum;
        p.last = (j == n - 1);
        product_q.push_back(p);
      end
    end
  endtask

  task automatic send_cmd(logic [ACT_W-1:0] act, int r, int c, logic [DATA_W-1:0] v);
    while (!steady && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.in_row   <= r[IDX_W-1:0];
    in_if.in_col   <= c[IDX_W-1:0];
    in_if.in_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_cmd(act, r, c, v);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_order(logic [ORDER_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_reg = v;
  endtask

  task automatic load_square(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        send_cmd(ACT_LOAD_A, r, c, pick_value());
        send_cmd(ACT_LOAD_B, r, c, pick_value());
      end
  endtask

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    product_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (product_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_if.out_value, '0);
      end else begin
        want = product_q.pop_front();
        if (out_if.out_row !== want.row) report_mismatch("out_row", out_if.out_row, want.row);
        if (out_if.out_col !== want.col) report_mismatch("out_col", out_if.out_col, want.col);
        if (out_if.out_value !== want.value)
          report_mismatch("out_value", out_if.out_value, want.value);
        if (out_if.last_of_row !== want.last)
          report_mismatch("last_of_row", out_if.last_of_row, want.last);
      end
    end
    out_if.ready <= steady || ($urandom_range(99) >= 13);
  end

  task automatic test_full_order();
    for (int r = 0; r < STORE_N; r++)
      for (int c = 0; c < STORE_N; c++)
        send_cmd(ACT_LOAD_B, r, c, pick_value());
    for (int c = 0; c < STORE_N; c++) begin
      send_cmd(ACT_LOAD_A, 0, c, pick_value());
      send_cmd(ACT_LOAD_A, 15, c, (c % 2) ? 32'h8000_0000 : 32'h7fff_ffff);
    end
    send_cmd(ACT_COMPUTE, 15, 9, 32'hffff_ffff);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
  endtask

  task automatic test_edge_cases();
    set_order(5'd2);
    send_cmd(ACT_LOAD_A, 0, 0, 32'h8000_0000);
    send_cmd(ACT_LOAD_A, 0, 1, 32'h7fff_ffff);
    send_cmd(ACT_LOAD_A, 1, 0, 32'hffff_ffff);
    send_cmd(ACT_LOAD_A, 1, 1, 32'h0);
    send_cmd(ACT_LOAD_B, 0, 0, 32'h8000_0000);
    send_cmd(ACT_LOAD_B, 0, 1, 32'hffff_ffff);
    send_cmd(ACT_LOAD_B, 1, 0, 32'h7fff_ffff);
    send_cmd(ACT_LOAD_B, 1, 1, 32'h1);
    send_cmd(ACT_LOAD_A, 2, 0, 32'h1234_5678);
    send_cmd(ACT_LOAD_B, 0, 2, 32'h1234_5678);
    send_cmd(ACT_LOAD_A, 15, 15, 32'hdead_beef);
    send_cmd(ACT_UNUSED, 1, 1, 32'hffff_ffff);
    send_cmd(ACT_COMPUTE, 2, 0, 32'h0);
    send_cmd(ACT_COMPUTE, 15, 15, 32'h0);
    send_cmd(ACT_COMPUTE, 0, 15, 32'h0);
    send_cmd(ACT_COMPUTE, 1, 0, 32'h0);
    set_order(5'd1);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
    send_cmd(ACT_COMPUTE, 1, 0, 32'h0);
    set_order(5'd0);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
    send_cmd(ACT_LOAD_A, 0, 0, 32'h5555_5555);
    set_order(5'd31);
    send_cmd(ACT_COMPUTE, 15, 0, 32'h0);
  endtask

  task automatic test_random();
    int sent;
    int n;
    int r;
    int c;
    int ops;
    sent = 0;
    while (sent < 80) begin
      case ($urandom_range(9))
        0: set_order(5'd0);
        1: set_order(5'($urandom_range(31, 16)));
        default: set_order(5'($urandom_range(6, 1)));
      endcase
      n = live_order();
      steady = ($urandom_range(3) == 0);
      if (n > 0 && n < 8) begin
        load_square(n);
        sent += 2 * n * n;
      end
      ops = $urandom_range(20, 6);
      for (int i = 0; i < ops; i++) begin
        r = $urandom_range(15);
        c = $urandom_range(15);
        case ($urandom_range(9))
          0: send_cmd(ACT_UNUSED, r, c, $urandom);
          1, 2: send_cmd(($urandom_range(1) != 0) ? ACT_LOAD_A : ACT_LOAD_B,
                         (n > 0) ? r % n : r, (n > 0) ? c % n : c, pick_value());
          3: send_cmd(ACT_LOAD_A, r, c, pick_value());
          default: begin
            if (n > 0 && r >= n) r = r % n;
            if ($urandom_range(4) == 0) r = $urandom_range(15);
            if (r >= n || row_ready(r)) send_cmd(ACT_COMPUTE, r, c, $urandom);
          end
        endcase
        sent++;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.action   = ACT_LOAD_A;
    in_if.in_row   = '0;
    in_if.in_col   = '0;
    in_if.in_value = '0;
    out_if.ready   = 1'b0;
    for (int i = 0; i < STORE_N*STORE_N; i++) begin
      left_mat[i] = '0;
      right_mat[i] = '0;
      left_set[i] = 1'b0;
      right_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_order();
    test_edge_cases();
    test_random();
    set_order(5'd16);
    send_cmd(ACT_COMPUTE, 15, 0, 32'h0);
    drain_results();
    if (errors == 0) begin
      $display("integer_matrix_multiply test passed");
    end else begin
      $display("integer_matrix_multiply test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/imm_pkg.sv
design/imm_in_if.sv
design/imm_out_if.sv
design/imm_front.sv
design/imm_queue.sv
design/imm_back.sv
design/integer_matrix_multiply.sv
tb/tb.sv
